// File: sv/beq_pkg.sv
// Shared types, constants and register codes for the button event qualifier.
package beq_pkg;

    // Button count handed to the top level by default
    localparam int NumKeysDefault = 3;
    // The payload fields carry three buttons at most
    localparam int FieldKeys = 3;
    // A scan yields at most one event per button
    localparam int MaxEvents = FieldKeys;
    localparam int EvCntW = $clog2(MaxEvents + 1);
    localparam int EvIdxW = $clog2(MaxEvents);

    // APB address width: four registers at 4-byte spacing
    localparam int CfgAddrW = 4;

    // Configuration reset values
    localparam logic [9:0]  PollIntervalReset = 10'd20;
    localparam logic [13:0] RepeatDelayReset  = 14'd300;
    localparam logic [15:0] LongPressReset    = 16'd1800;
    localparam logic [13:0] RampSpanReset     = 14'd2000;

    // Repeat divisor step is 200 ms: x/200 == (x >> 3)/25, and for
    // y < 2048, y/25 == (y * 5243) >> 17 exactly.
    localparam int          RampPreShift   = 3;
    localparam logic [12:0] RampRecip      = 13'd5243;
    localparam int          RampRecipShift = 17;
    localparam int          RampDivW       = 7;

    typedef enum logic [1:0] {
        EV_PRESS  = 2'd0,
        EV_CLICK  = 2'd1,
        EV_REPEAT = 2'd2,
        EV_LONG   = 2'd3
    } ev_kind_t;

    typedef enum logic [1:0] {
        REG_POLL_INTERVAL = 2'd0,
        REG_REPEAT_DELAY  = 2'd1,
        REG_LONG_PRESS    = 2'd2,
        REG_RAMP_SPAN     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [2:0] button_levels;
        logic [2:0] press_consumed;
    } tick_t;

    typedef struct packed {
        logic [1:0] button_index;
        logic [1:0] event_kind;
        logic       last_event;
    } evt_t;

    typedef struct packed {
        logic [9:0]  poll_interval_ms;
        logic [13:0] repeat_delay_ms;
        logic [15:0] long_press_ms;
        logic [13:0] ramp_span_ms;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic start_scan;
        logic load_dif;
        logic eval;
        logic next_key;
        logic load_ramp;
        logic load_div;
        logic repeat_apply;
        logic pop;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_due;
        logic need_repeat;
        logic last_key;
        logic mod_done;
        logic ev_empty;
        logic pop_last;
    } sts_t;

endpackage

// File: sv/beq_mod.sv
// Iterative remainder unit: 32-bit count modulo a 7-bit divisor, two bits per cycle.
module beq_mod (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [31:0]                       dividend,
    input  logic [beq_pkg::RampDivW-1:0]      divisor,
    output logic                              done,
    output logic                              rem_zero
);

    localparam int DividendW = 32;
    localparam int DivW      = beq_pkg::RampDivW;
    localparam int Steps     = DividendW / 2;
    localparam int StepCntW  = $clog2(Steps);
    localparam logic [StepCntW-1:0] LastStep = StepCntW'(Steps - 1);

    logic [DividendW-1:0] shift_reg;
    logic [DivW-1:0]      rem_reg;
    logic [StepCntW-1:0]  step_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DivW:0]   trial0;
    logic [DivW:0]   trial1;
    logic [DivW:0]   div_ext;
    logic [DivW-1:0] rem0;
    logic [DivW-1:0] rem1;

    // Two restoring steps per cycle
    always_comb
    begin
        div_ext = {1'b0, divisor};
        trial0  = {rem_reg, shift_reg[DividendW-1]};
        rem0    = (trial0 >= div_ext) ? DivW'(trial0 - div_ext) : trial0[DivW-1:0];
        trial1  = {rem0, shift_reg[DividendW-2]};
        rem1    = (trial1 >= div_ext) ? DivW'(trial1 - div_ext) : trial1[DivW-1:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LastStep);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LastStep)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[DividendW-3:0], 2'b00};
            rem_reg   <= rem1;
        end
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("remainder done while still busy");

endmodule

// File: sv/beq_dp.sv
// Datapath: counters, shared hold state, ramp divisor, event buffer.
module beq_dp #(
    parameter int NUM_KEYS = beq_pkg::NumKeysDefault
) (
    input  logic           clk,
    input  logic           rst_n,
    input  beq_pkg::cfg_t  cfg,
    input  beq_pkg::tick_t tick,
    input  beq_pkg::cmd_t  cmd,
    output beq_pkg::sts_t  sts,
    output beq_pkg::evt_t  evt
);

    localparam int ScanKeys = (NUM_KEYS < beq_pkg::FieldKeys) ? NUM_KEYS : beq_pkg::FieldKeys;
    localparam logic [1:0] LastKey = 2'(ScanKeys - 1);
    localparam int EvCntW = beq_pkg::EvCntW;
    localparam int EvIdxW = beq_pkg::EvIdxW;
    localparam int DivW   = beq_pkg::RampDivW;
    localparam int ProdW  = 14 - beq_pkg::RampPreShift + 13;

    typedef struct packed {
        logic [1:0]        key;
        beq_pkg::ev_kind_t kind;
    } ev_entry_t;

    // Latched tick
    logic [2:0]  levels_reg;
    logic [2:0]  consumed_reg;
    // Time and shared hold state
    logic [31:0] ms_cnt_reg;
    logic [31:0] last_poll_reg;
    logic [31:0] hold_start_reg;
    logic [31:0] repeat_cnt_reg;
    logic [2:0]  pressed_reg;
    logic        handled_reg;
    logic [1:0]  key_reg;
    // Per-key working values
    logic [31:0] dif_reg;
    logic [31:0] over_reg;
    logic [13:0] ramp_reg;
    logic [DivW-1:0] div_reg;
    // Event buffer
    ev_entry_t         ev_buf_reg [beq_pkg::MaxEvents];
    logic [EvCntW-1:0] ev_cnt_reg;
    logic [EvIdxW-1:0] rd_reg;

    logic [31:0]     poll_sum;
    logic [2:0]      key_mask;
    logic            was_down;
    logic            is_down;
    logic            changed;
    logic            do_long;
    logic            need_repeat;
    logic [13:0]     ramp_x;
    logic [ProdW-1:0] recip_prod;
    logic [DivW-1:0] ramp_quot;
    logic            mod_done;
    logic            mod_rem_zero;
    logic            push;
    beq_pkg::ev_kind_t push_kind;
    logic [EvCntW-1:0] ev_last;

    // Scan decisions
    always_comb
    begin
        poll_sum    = last_poll_reg + 32'(cfg.poll_interval_ms);
        key_mask    = 3'b001 << key_reg;
        was_down    = pressed_reg[key_reg];
        is_down     = !levels_reg[key_reg];
        changed     = (was_down != is_down);
        do_long     = !changed && is_down && (key_reg == 2'd0) && !handled_reg
                      && (dif_reg > 32'(cfg.long_press_ms));
        need_repeat = !changed && is_down && (key_reg != 2'd0)
                      && (dif_reg > 32'(cfg.repeat_delay_ms));
    end

    // Repeat divisor: (span - over) / 200, at least one
    always_comb
    begin
        ramp_x     = (over_reg >= 32'(cfg.ramp_span_ms))
                     ? 14'd0 : (cfg.ramp_span_ms - over_reg[13:0]);
        recip_prod = ProdW'(ramp_reg[13:beq_pkg::RampPreShift]) * ProdW'(beq_pkg::RampRecip);
        ramp_quot  = recip_prod[ProdW-1:beq_pkg::RampRecipShift];
    end

    // Event push
    always_comb
    begin
        push      = 1'b0;
        push_kind = beq_pkg::EV_PRESS;
        if (cmd.eval && changed)
        begin
            if (is_down)
            begin
                push      = 1'b1;
                push_kind = beq_pkg::EV_PRESS;
            end
            else if (!handled_reg)
            begin
                push      = 1'b1;
                push_kind = beq_pkg::EV_CLICK;
            end
        end
        else if (cmd.eval && do_long)
        begin
            push      = 1'b1;
            push_kind = beq_pkg::EV_LONG;
        end
        else if (cmd.repeat_apply && mod_rem_zero)
        begin
            push      = 1'b1;
            push_kind = beq_pkg::EV_REPEAT;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_cnt_reg     <= '0;
            last_poll_reg  <= '0;
            hold_start_reg <= '0;
            repeat_cnt_reg <= '0;
            pressed_reg    <= '0;
            handled_reg    <= 1'b0;
            key_reg        <= '0;
            ev_cnt_reg     <= '0;
            rd_reg         <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                ms_cnt_reg <= ms_cnt_reg + 32'd1;
            end
            if (cmd.start_scan)
            begin
                last_poll_reg <= ms_cnt_reg;
                key_reg       <= '0;
                ev_cnt_reg    <= '0;
                rd_reg        <= '0;
            end
            if (cmd.next_key)
            begin
                key_reg <= key_reg + 2'd1;
            end
            if (cmd.eval && changed)
            begin
                repeat_cnt_reg <= '0;
                if (is_down)
                begin
                    pressed_reg    <= pressed_reg | key_mask;
                    handled_reg    <= consumed_reg[key_reg];
                    hold_start_reg <= ms_cnt_reg;
                end
                else
                begin
                    pressed_reg    <= pressed_reg & ~key_mask;
                    handled_reg    <= 1'b0;
                    hold_start_reg <= '0;
                end
            end
            else if (cmd.eval && do_long)
            begin
                hold_start_reg <= '0;
                repeat_cnt_reg <= '0;
                handled_reg    <= 1'b1;
            end
            if (cmd.repeat_apply)
            begin
                repeat_cnt_reg <= repeat_cnt_reg + 32'd1;
            end
            if (push)
            begin
                ev_cnt_reg <= ev_cnt_reg + 1'b1;
            end
            if (cmd.pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    // Working values and buffer
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            levels_reg   <= tick.button_levels;
            consumed_reg <= tick.press_consumed;
        end
        if (cmd.load_dif)
        begin
            dif_reg <= ms_cnt_reg - hold_start_reg;
        end
        if (cmd.eval)
        begin
            over_reg <= dif_reg - 32'(cfg.repeat_delay_ms);
        end
        if (cmd.load_ramp)
        begin
            ramp_reg <= ramp_x;
        end
        if (cmd.load_div)
        begin
            div_reg <= (ramp_quot == '0) ? DivW'(1) : ramp_quot;
        end
        if (push)
        begin
            ev_buf_reg[ev_cnt_reg[EvIdxW-1:0]] <= '{key: key_reg, kind: push_kind};
        end
    end

    beq_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load_div),
        .dividend (repeat_cnt_reg),
        .divisor  (div_reg),
        .done     (mod_done),
        .rem_zero (mod_rem_zero)
    );

    // Status and output beat
    assign ev_last = ev_cnt_reg - 1'b1;

    always_comb
    begin
        sts.scan_due    = (ms_cnt_reg > poll_sum);
        sts.need_repeat = need_repeat;
        sts.last_key    = (key_reg == LastKey);
        sts.mod_done    = mod_done;
        sts.ev_empty    = (ev_cnt_reg == '0);
        sts.pop_last    = (EvCntW'(rd_reg) == ev_last);

        evt.button_index = ev_buf_reg[rd_reg].key;
        evt.event_kind   = ev_buf_reg[rd_reg].kind;
        evt.last_event   = (EvCntW'(rd_reg) == ev_last);
    end

    a_ev_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ev_cnt_reg <= EvCntW'(beq_pkg::MaxEvents))
        else $error("event buffer overfilled");

    a_mask_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (pressed_reg != $past(pressed_reg)) |-> $past(cmd.eval))
        else $error("pressed mask changed outside a key evaluation");

    a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (EvCntW'(rd_reg) < ev_last))
        else $error("pop beyond last buffered event");

endmodule

// File: sv/beq_ctrl.sv
// Controller: sequences tick intake, per-button scan, repeat check and event delivery.
module beq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tick_valid,
    output logic          tick_stall,
    output logic          evt_valid,
    input  logic          evt_stall,
    input  beq_pkg::sts_t sts,
    output beq_pkg::cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_POLL   = 10'b00_0000_0010,
        S_KEY    = 10'b00_0000_0100,
        S_EVAL   = 10'b00_0000_1000,
        S_RAMP   = 10'b00_0001_0000,
        S_DIV    = 10'b00_0010_0000,
        S_MOD    = 10'b00_0100_0000,
        S_REP    = 10'b00_1000_0000,
        S_FINISH = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (tick_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_POLL;
                end
            end
            S_POLL:
            begin
                if (sts.scan_due)
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = S_KEY;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_KEY:
            begin
                cmd.load_dif = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.need_repeat)
                begin
                    state_next = S_RAMP;
                end
                else if (sts.last_key)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.next_key = 1'b1;
                    state_next   = S_KEY;
                end
            end
            S_RAMP:
            begin
                cmd.load_ramp = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.load_div = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_REP;
                end
            end
            S_REP:
            begin
                cmd.repeat_apply = 1'b1;
                if (sts.last_key)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.next_key = 1'b1;
                    state_next   = S_KEY;
                end
            end
            S_FINISH:
            begin
                state_next = sts.ev_empty ? S_IDLE : S_EMIT;
            end
            S_EMIT:
            begin
                if (!evt_stall)
                begin
                    if (sts.pop_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.pop = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign tick_stall = (state_reg != S_IDLE);
    assign evt_valid  = (state_reg == S_EMIT);

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !sts.ev_empty)
        else $error("delivering beats from an empty event buffer");

endmodule

// File: sv/button_event_qualifier.sv
// Top level: APB register file, controller and datapath of the button event qualifier.

// Each tick beat is one millisecond and carries three active-low button levels plus the
// handler's consumed mask; the block emits press, click, repeat and long-click beats,
// marking the last beat of each tick. One tick is held at a time. A scan evaluates each
// button in turn; each held button other than button 0 that is past its repeat delay also
// runs the shared remainder unit, which clears two bits of the 32-bit repeat count per
// cycle. Buffered event beats are then delivered, held while evt_stall is high.
// Registers sit at byte addresses 0 (poll interval), 4 (repeat delay), 8 (long press)
// and 12 (ramp span); there is no clearing pass after reset.
module button_event_qualifier #(
    parameter int NUM_KEYS = beq_pkg::NumKeysDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [beq_pkg::CfgAddrW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          tick_valid,
    output logic                          tick_stall,
    input  beq_pkg::tick_t                tick,
    output logic                          evt_valid,
    input  logic                          evt_stall,
    output beq_pkg::evt_t                 evt
);

    beq_pkg::cfg_t     cfg_reg;
    beq_pkg::reg_idx_t reg_idx;
    logic              cfg_write;
    beq_pkg::cmd_t     cmd;
    beq_pkg::sts_t     sts;

    // Register decode
    assign reg_idx   = beq_pkg::reg_idx_t'(paddr[beq_pkg::CfgAddrW-1:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval_ms <= beq_pkg::PollIntervalReset;
            cfg_reg.repeat_delay_ms  <= beq_pkg::RepeatDelayReset;
            cfg_reg.long_press_ms    <= beq_pkg::LongPressReset;
            cfg_reg.ramp_span_ms     <= beq_pkg::RampSpanReset;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                beq_pkg::REG_POLL_INTERVAL: cfg_reg.poll_interval_ms <= pwdata[9:0];
                beq_pkg::REG_REPEAT_DELAY:  cfg_reg.repeat_delay_ms  <= pwdata[13:0];
                beq_pkg::REG_LONG_PRESS:    cfg_reg.long_press_ms    <= pwdata[15:0];
                beq_pkg::REG_RAMP_SPAN:     cfg_reg.ramp_span_ms     <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            beq_pkg::REG_POLL_INTERVAL: prdata = 32'(cfg_reg.poll_interval_ms);
            beq_pkg::REG_REPEAT_DELAY:  prdata = 32'(cfg_reg.repeat_delay_ms);
            beq_pkg::REG_LONG_PRESS:    prdata = 32'(cfg_reg.long_press_ms);
            beq_pkg::REG_RAMP_SPAN:     prdata = 32'(cfg_reg.ramp_span_ms);
            default:                    prdata = '0;
        endcase
    end

    beq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    beq_dp #(
        .NUM_KEYS (NUM_KEYS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .tick  (tick),
        .cmd   (cmd),
        .sts   (sts),
        .evt   (evt)
    );

endmodule

// File: tb/button_event_qualifier_test.sv
// Self-checking testbench for the button event qualifier: event prediction, scoreboard, stimulus.
`timescale 1ns / 100ps

module button_event_qualifier_test;

    localparam int RampStepMs   = 200;
    localparam int SettleCycles = 64;
    localparam int MaxReports   = 10;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [beq_pkg::CfgAddrW-1:0] paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         tick_valid = 1'b0;
    logic                         tick_stall;
    beq_pkg::tick_t               tick = '0;
    logic                         evt_valid;
    logic                         evt_stall = 1'b0;
    beq_pkg::evt_t                evt;

    // Predicts the event beats of every accepted tick and checks the delivered ones
    class event_scoreboard;
        logic [9:0]    poll_ms;
        logic [13:0]   repeat_ms;
        logic [15:0]   long_ms;
        logic [13:0]   ramp_ms;
        logic [2:0]    down_mask;
        logic [31:0]   now_ms;
        logic [31:0]   last_scan_ms;
        logic [31:0]   hold_start_ms;
        logic [31:0]   repeat_cnt;
        logic          handled;
        beq_pkg::evt_t expected_events[$];
        int            fails;
        int            ticks;
        int            beats;
        int            kind_seen[4];

        function new();
            poll_ms       = beq_pkg::PollIntervalReset;
            repeat_ms     = beq_pkg::RepeatDelayReset;
            long_ms       = beq_pkg::LongPressReset;
            ramp_ms       = beq_pkg::RampSpanReset;
            down_mask     = '0;
            now_ms        = '0;
            last_scan_ms  = '0;
            hold_start_ms = '0;
            repeat_cnt    = '0;
            handled       = 1'b0;
            fails         = 0;
            ticks         = 0;
            beats         = 0;
            kind_seen     = '{0, 0, 0, 0};
        endfunction

        function void fail(string what);
            fails++;
            if (fails <= MaxReports)
                $display("MISMATCH: %s", what);
        endfunction

        function void write_reg(beq_pkg::reg_idx_t idx, logic [31:0] value);
            case (idx)
                beq_pkg::REG_POLL_INTERVAL: poll_ms   = value[9:0];
                beq_pkg::REG_REPEAT_DELAY:  repeat_ms = value[13:0];
                beq_pkg::REG_LONG_PRESS:    long_ms   = value[15:0];
                beq_pkg::REG_RAMP_SPAN:     ramp_ms   = value[13:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(beq_pkg::reg_idx_t idx);
            case (idx)
                beq_pkg::REG_POLL_INTERVAL: return 32'(poll_ms);
                beq_pkg::REG_REPEAT_DELAY:  return 32'(repeat_ms);
                beq_pkg::REG_LONG_PRESS:    return 32'(long_ms);
                default:                    return 32'(ramp_ms);
            endcase
        endfunction

        function int outstanding();
            return expected_events.size();
        endfunction

        function void push_event(int key, beq_pkg::ev_kind_t kind);
            expected_events.push_back(beq_pkg::evt_t'{button_index: 2'(key),
                                                      event_kind: kind,
                                                      last_event: 1'b0});
        endfunction

        // One millisecond tick: advance the clock, scan when the poll interval is exceeded
        function void take_tick(beq_pkg::tick_t t);
            logic [31:0] held_ms;
            logic [31:0] over_ms;
            logic [31:0] span_left;
            logic [31:0] divisor;
            logic        now_down;
            logic        was_down;
            int          first;
            first = expected_events.size();
            ticks++;
            now_ms = now_ms + 32'd1;
            if (now_ms > last_scan_ms + 32'(poll_ms))
            begin
                last_scan_ms = now_ms;
                for (int k = 0; k < beq_pkg::FieldKeys; k++)
                begin
                    now_down = !t.button_levels[k];
                    was_down = down_mask[k];
                    if (now_down != was_down)
                    begin
                        hold_start_ms = now_ms;
                        repeat_cnt    = '0;
                        if (now_down)
                        begin
                            down_mask[k] = 1'b1;
                            handled      = t.press_consumed[k];
                            push_event(k, beq_pkg::EV_PRESS);
                        end
                        else
                        begin
                            // release: click unless consumed, then clear shared hold state
                            down_mask[k] = 1'b0;
                            if (!handled)
                                push_event(k, beq_pkg::EV_CLICK);
                            hold_start_ms = '0;
                            repeat_cnt    = '0;
                            handled       = 1'b0;
                        end
                    end
                    else if (now_down)
                    begin
                        held_ms = now_ms - hold_start_ms;
                        if (k > 0)
                        begin
                            // auto-repeat with a divisor ramping down to one
                            if (held_ms > 32'(repeat_ms))
                            begin
                                over_ms   = held_ms - 32'(repeat_ms);
                                span_left = (over_ms >= 32'(ramp_ms)) ? 32'd0
                                                                      : 32'(ramp_ms) - over_ms;
                                divisor   = span_left / RampStepMs;
                                if (divisor == 0)
                                    divisor = 32'd1;
                                if (repeat_cnt % divisor == 0)
                                    push_event(k, beq_pkg::EV_REPEAT);
                                repeat_cnt = repeat_cnt + 32'd1;
                            end
                        end
                        else if (!handled && held_ms > 32'(long_ms))
                        begin
                            hold_start_ms = '0;
                            repeat_cnt    = '0;
                            handled       = 1'b1;
                            push_event(k, beq_pkg::EV_LONG);
                        end
                    end
                end
            end
            if (expected_events.size() > first)
                expected_events[expected_events.size() - 1].last_event = 1'b1;
        endfunction

        function void check_event(beq_pkg::evt_t got);
            beq_pkg::evt_t want;
            if (expected_events.size() == 0)
            begin
                fail($sformatf("beat with nothing expected: key %0d kind %0d last %0d",
                               got.button_index, got.event_kind, got.last_event));
                return;
            end
            want = expected_events.pop_front();
            beats++;
            if (got.button_index !== want.button_index || got.event_kind !== want.event_kind ||
                got.last_event !== want.last_event)
                fail($sformatf("beat %0d: expected key %0d kind %0d last %0d, got %0d %0d %0d",
                               beats, want.button_index, want.event_kind, want.last_event,
                               got.button_index, got.event_kind, got.last_event));
            else
                kind_seen[want.event_kind]++;
        endfunction
    endclass

    event_scoreboard sb = new();
    logic            quiet = 1'b0;
    int              stall_left = 0;
    int              settings_used = 1;

    button_event_qualifier u_top (
        .clk,
        .rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .tick_valid,
        .tick_stall,
        .tick,
        .evt_valid,
        .evt_stall,
        .evt
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Event side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            evt_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            evt_stall <= 1'b1;
            stall_left = $urandom_range(0, 14);
        end
        else
        begin
            evt_stall <= 1'b0;
        end
    end

    // Event beat monitor
    always @(posedge clk)
    begin
        if (rst_n && evt_valid && !evt_stall)
            sb.check_event(evt);
    end

    // Tick beat, with an optional idle burst ahead of it
    task automatic send_tick(input beq_pkg::tick_t t);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        do @(posedge clk); while (tick_stall);
        sb.take_tick(t);
    endtask

    task automatic hold_levels(input logic [2:0] levels, input logic [2:0] consumed,
                               input int count);
        for (int j = 0; j < count; j++)
            send_tick(beq_pkg::tick_t'{button_levels: levels, press_consumed: consumed});
    endtask

    // Stop sending, wait for every predicted beat, then let the block finish a silent scan
    task automatic settle();
        tick_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic reg_write(input beq_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_check(input beq_pkg::reg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== sb.reg_value(idx))
            sb.fail($sformatf("register %s: expected %0d, read %0d", idx.name(),
                              sb.reg_value(idx), prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write all four registers (junk above each field width) and read them back
    task automatic apply_settings(input logic [31:0] poll, input logic [31:0] rdelay,
                                  input logic [31:0] lpress, input logic [31:0] ramp);
        logic [31:0] vals[4];
        int          widths[4];
        settle();
        vals   = '{poll, rdelay, lpress, ramp};
        widths = '{10, 14, 16, 14};
        for (int r = 0; r < 4; r++)
        begin
            if ($urandom_range(0, 1) == 1)
                vals[r] = vals[r] | (32'($urandom()) << widths[r]);
            reg_write(beq_pkg::reg_idx_t'(r), vals[r]);
        end
        for (int r = 0; r < 4; r++)
            reg_check(beq_pkg::reg_idx_t'(r));
        settings_used++;
    endtask

    // Mostly held level patterns of random length, some single-tick noise
    task automatic run_random(input int count, input int hold_max);
        beq_pkg::tick_t t;
        int             run_len;
        int             sent;
        sent = 0;
        while (sent < count)
        begin
            t.button_levels = 3'($urandom_range(0, 7));
            run_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, hold_max) : 1;
            for (int j = 0; j < run_len && sent < count; j++)
            begin
                t.press_consumed = 3'($urandom_range(0, 7));
                send_tick(t);
                sent++;
            end
            if (!quiet && $urandom_range(0, 39) == 0)
            begin
                tick_valid <= 1'b0;
                do @(posedge clk); while (sb.outstanding() != 0);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        run_random(30, 25);

        // directed: scan every other tick, zero hold times
        apply_settings(32'd1, 32'd0, 32'd0, 32'd600);
        hold_levels(3'b111, 3'b000, 2);
        // button 0 press, long click once, no second long click, release without click
        hold_levels(3'b110, 3'b000, 2);
        hold_levels(3'b110, 3'b000, 2);
        hold_levels(3'b110, 3'b000, 2);
        hold_levels(3'b111, 3'b000, 2);
        // all three pressed in one scan, then shared hold state across buttons
        hold_levels(3'b000, 3'b000, 2);
        hold_levels(3'b000, 3'b000, 2);
        hold_levels(3'b111, 3'b111, 2);
        // consumed presses suppress clicks until the shared flag is cleared
        hold_levels(3'b000, 3'b111, 2);
        hold_levels(3'b111, 3'b000, 2);
        hold_levels(3'b101, 3'b010, 2);
        hold_levels(3'b111, 3'b000, 2);

        // random phases over low, mid and high register settings
        apply_settings(32'd1, 32'd0, 32'd0, 32'd0);
        run_random(40, 12);
        apply_settings(32'd3, 32'd10, 32'd20, 32'd1000);
        run_random(40, 30);
        apply_settings(32'd1, 32'd6, 32'd10, 32'd3000);
        run_random(30, 30);
        apply_settings(32'd1000, 32'd10000, 32'd60000, 32'd10000);
        run_random(10, 10);
        apply_settings($urandom_range(1, 4), $urandom_range(0, 40), $urandom_range(0, 60),
                       $urandom_range(0, 1500));
        quiet = 1'b1;
        run_random(25, 30);

        // drain
        tick_valid <= 1'b0;
        for (int c = 0; c < 20000 && sb.outstanding() != 0; c++) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.fail($sformatf("%0d predicted beats never arrived", sb.outstanding()));

        $display("Ran %0d ticks under %0d register settings, %0d event beats checked.",
                 sb.ticks, settings_used, sb.beats);
        $display("Beats by kind: press %0d, click %0d, repeat %0d, long click %0d.",
                 sb.kind_seen[beq_pkg::EV_PRESS], sb.kind_seen[beq_pkg::EV_CLICK],
                 sb.kind_seen[beq_pkg::EV_REPEAT], sb.kind_seen[beq_pkg::EV_LONG]);
        if (sb.fails == 0)
            $display("button_event_qualifier_test OK");
        else
            $display("button_event_qualifier_test NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("Timeout with %0d beats still expected.", sb.outstanding());
        $display("button_event_qualifier_test NOT OK");
        $finish;
    end

endmodule
